### hw/rtl/rbsi_pkg.sv
// shared constants for the ray versus box slab test
// no dependencies

package rbsi_pkg;

  localparam int OUTCOME_W = 2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_BEHIND = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_MISS   = 2'd2;

  localparam int NUM_FIELDS = 12;
  localparam int NUM_AXES   = 3;

endpackage

### hw/rtl/ray_box_slab_intersect.sv
// throughput: one beat per cycle while m_tready is high; each of the six
// slab divisions is a pipeline of COORD_WIDTH one-bit subtract stages, so the
// divider chain sets the latency
// a stall holds each stage only as far back as the first empty slot
// reset clears all stage valid bits; payload registers are not reset
// depends on rbsi_pkg and rbsi_div

module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [((NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // outcome, t_value
  output logic [((OUTCOME_W+COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready
);

  localparam int W      = COORD_WIDTH;
  localparam int DEPTH  = W + 8;
  localparam int OUT_W  = ((OUTCOME_W + W + 7) / 8) * 8;
  localparam int DIV0   = 2;

  logic [DEPTH-1:0] v;
  logic [DEPTH:0]   rdy;

  always_comb begin
    rdy[DEPTH] = m_tready;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // input register
  logic [W-1:0] fin [0:NUM_FIELDS-1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        fin[i] <= s_tdata[i*W +: W];
      end
    end
  end

  // bound minus origin
  logic [W:0]   dif [0:5];
  logic [W-1:0] dr  [0:NUM_AXES-1];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 6; i++) begin
        dif[i] <= {fin[i][W-1], fin[i]} - {fin[6 + (i % 3)][W-1], fin[6 + (i % 3)]};
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        dr[i] <= fin[9 + i];
      end
    end
  end

  logic [W-1:0] quo [0:5];

  genvar j;
  generate
    for (j = 0; j < 6; j++) begin : g_div
      rbsi_div #(
        .W (W),
        .F (FRAC_BITS)
      ) u_div (
        .clk (clk),
        .en  (rdy[DIV0 + W + 2:DIV0]),
        .num (dif[j]),
        .den (dr[j % 3]),
        .q   (quo[j])
      );
    end
  endgenerate

  // per-axis ordering
  logic signed [W-1:0] lo [0:NUM_AXES-1];
  logic signed [W-1:0] hi [0:NUM_AXES-1];

  always_ff @(posedge clk) begin
    if (rdy[W+5]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if ($signed(quo[a]) < $signed(quo[a+3])) begin
          lo[a] <= quo[a];
          hi[a] <= quo[a+3];
        end else begin
          lo[a] <= quo[a+3];
          hi[a] <= quo[a];
        end
      end
    end
  end

  // near and far
  logic signed [W-1:0] tnear, tfar, near01, far01;

  assign near01 = (lo[1] > lo[0]) ? lo[1] : lo[0];
  assign far01  = (hi[1] < hi[0]) ? hi[1] : hi[0];

  always_ff @(posedge clk) begin
    if (rdy[W+6]) begin
      tnear <= (lo[2] > near01) ? lo[2] : near01;
      tfar  <= (hi[2] < far01) ? hi[2] : far01;
    end
  end

  // classify
  logic [OUTCOME_W-1:0] outcome;
  logic [W-1:0]         t_value;

  always_ff @(posedge clk) begin
    if (rdy[W+7]) begin
      if (tfar[W-1]) begin
        outcome <= OUTCOME_BEHIND;
        t_value <= tfar;
      end else if (tnear > tfar) begin
        outcome <= OUTCOME_MISS;
        t_value <= tfar;
      end else begin
        outcome <= OUTCOME_HIT;
        t_value <= tnear;
      end
    end
  end

  assign m_tdata = OUT_W'({t_value, outcome});

endmodule

### hw/rtl/rbsi_div.sv
// pipelined fixed point divider, one quotient bit per stage, saturating
// no package dependencies

module rbsi_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic [W+2:0] en,
  input  logic [W:0]   num,
  input  logic [W-1:0] den,
  output logic [W-1:0] q
);

  localparam int CMPW = ((F + 1 > W) ? F + 1 : W) + 1;
  localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

  logic [W:0]   a_n;
  logic [W-1:0] a_d;
  logic         a_neg, a_dz, a_npos, a_nneg;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_n    <= num[W] ? (~num + 1'b1) : num;
      a_d    <= den[W-1] ? (~den + 1'b1) : den;
      a_neg  <= num[W] ^ den[W-1];
      a_dz   <= (den == '0);
      a_npos <= !num[W] && (num != '0);
      a_nneg <= num[W];
    end
  end

  logic [W+F:0] nx;
  logic [F:0]   hi;
  logic         sat0;

  assign nx   = {a_n, {F{1'b0}}};
  assign hi   = nx[W+F:W];
  assign sat0 = CMPW'(hi) >= CMPW'(a_d);

  logic [W-1:0] r  [0:W];
  logic [W-1:0] lo [0:W];
  logic [W-1:0] qq [0:W];
  logic [W-1:0] dd [0:W];
  logic         fneg [0:W];
  logic         fdz  [0:W];
  logic         fpos [0:W];
  logic         fnn  [0:W];
  logic         fsat [0:W];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r[0]    <= W'(hi);
      lo[0]   <= nx[W-1:0];
      qq[0]   <= '0;
      dd[0]   <= a_d;
      fneg[0] <= a_neg;
      fdz[0]  <= a_dz;
      fpos[0] <= a_npos;
      fnn[0]  <= a_nneg;
      fsat[0] <= sat0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_step
      logic [W:0] rs;
      logic       ge;
      assign rs = {r[k], lo[k][W-1]};
      assign ge = rs >= {1'b0, dd[k]};
      always_ff @(posedge clk) begin
        if (en[k+2]) begin
          r[k+1]    <= ge ? W'(rs - {1'b0, dd[k]}) : rs[W-1:0];
          lo[k+1]   <= {lo[k][W-2:0], 1'b0};
          qq[k+1]   <= {qq[k][W-2:0], ge};
          dd[k+1]   <= dd[k];
          fneg[k+1] <= fneg[k];
          fdz[k+1]  <= fdz[k];
          fpos[k+1] <= fpos[k];
          fnn[k+1]  <= fnn[k];
          fsat[k+1] <= fsat[k];
        end
      end
    end
  endgenerate

  logic [W-1:0] q_next;

  always_comb begin
    if (fdz[W]) begin
      q_next = fpos[W] ? POS_LIM : (fnn[W] ? NEG_LIM : '0);
    end else if (fneg[W]) begin
      q_next = (fsat[W] || (qq[W] > NEG_LIM)) ? NEG_LIM : (~qq[W] + 1'b1);
    end else begin
      q_next = (fsat[W] || qq[W][W-1]) ? POS_LIM : qq[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[W+2]) begin
      q <= q_next;
    end
  end

endmodule

### hw/rtl/rbsi_checker.sv
// port level checks for the slab test output stream
// depends on rbsi_pkg; bound to ray_box_slab_intersect

module rbsi_checker
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  input logic [((OUTCOME_W+COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic m_tvalid,
  input logic m_tready
);

  localparam int W = COORD_WIDTH;

  logic [OUTCOME_W-1:0] oc;
  logic                 tsign;

  assign oc    = m_tdata[OUTCOME_W-1:0];
  assign tsign = m_tdata[OUTCOME_W+W-1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (oc == OUTCOME_HIT) || (oc == OUTCOME_BEHIND) || (oc == OUTCOME_MISS))
    else $error("unused outcome code");

  a_behind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (oc == OUTCOME_BEHIND) |-> tsign)
    else $error("behind outcome with non-negative far distance");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (oc == OUTCOME_MISS) |-> !tsign)
    else $error("miss outcome with negative far distance");

  a_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat right after reset");

endmodule

bind ray_box_slab_intersect rbsi_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rbsi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

### sim/rbsi_checker.sv
// checker for the ray versus box slab test: watches both streams, predicts each result
// depends on rbsi_pkg
`timescale 1ns / 1ps

module rbsi_scoreboard
  import rbsi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [383:0] s_tdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  m_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  output int           fail_count,
  output int           pending
);

  localparam longint POS_LIM = 64'sd2147483647;
  localparam longint NEG_LIM = -64'sd2147483648;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [31:0]          t_value;
  } slab_result_t;

  slab_result_t hit_queue[$];

  function automatic longint slab_quot(longint num, longint den);
    logic             neg;
    logic [63:0]      n, d, qi, r, frac, q, lim;
    if (den == 0) begin
      if (num > 0) return POS_LIM;
      if (num < 0) return NEG_LIM;
      return 0;
    end
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    qi = n / d;
    r = n % d;
    if (qi > (lim >> 16)) return neg ? NEG_LIM : POS_LIM;
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= d) begin
        r = r - d;
        frac[0] = 1'b1;
      end
    end
    q = (qi << 16) | frac;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic slab_result_t slab_predict(logic [383:0] beat);
    longint tnear, tfar, ta, tb, lo, hi, o, d;
    slab_result_t res;
    tnear = 0;
    tfar = 0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      o = longint'($signed(beat[(6+ax)*32 +: 32]));
      d = longint'($signed(beat[(9+ax)*32 +: 32]));
      ta = slab_quot(longint'($signed(beat[ax*32 +: 32])) - o, d);
      tb = slab_quot(longint'($signed(beat[(3+ax)*32 +: 32])) - o, d);
      lo = ta < tb ? ta : tb;
      hi = ta > tb ? ta : tb;
      if (ax == 0) begin
        tnear = lo;
        tfar = hi;
      end else begin
        if (lo > tnear) tnear = lo;
        if (hi < tfar) tfar = hi;
      end
    end
    if (tfar < 0) begin
      res.outcome = OUTCOME_BEHIND;
      res.t_value = tfar[31:0];
    end else if (tnear > tfar) begin
      res.outcome = OUTCOME_MISS;
      res.t_value = tfar[31:0];
    end else begin
      res.outcome = OUTCOME_HIT;
      res.t_value = tnear[31:0];
    end
    return res;
  endfunction

  assign pending = hit_queue.size();

  always @(posedge clk) begin
    slab_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) hit_queue.push_back(slab_predict(s_tdata));
      if (m_tvalid && m_tready) begin
        if (hit_queue.size() == 0) begin
          $error("unexpected result beat %h", m_tdata);
          errs = errs + 1;
        end else begin
          want = hit_queue.pop_front();
          if (m_tdata[1:0] !== want.outcome) begin
            $error("outcome expected %0d actual %0d", want.outcome, m_tdata[1:0]);
            errs = errs + 1;
          end
          if (m_tdata[33:2] !== want.t_value) begin
            $error("t_value expected %h actual %h", want.t_value, m_tdata[33:2]);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### sim/tb.sv
// stimulus and verdict for the ray versus box slab test
// depends on rbsi_pkg, ray_box_slab_intersect and rbsi_scoreboard
`timescale 1ns / 1ps

module tb;
  import rbsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [383:0] s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  m_tdata;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           rx_stall_on = 1'b1;

  always #10 clk = ~clk;

  ray_box_slab_intersect u_dut (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
  );

  rbsi_scoreboard u_chk (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] coord_pick();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] dir_pick();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
      4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
    endcase
  endfunction

  // a box centred, per axis, a random multiple of that axis's direction away from the origin
  function automatic logic [383:0] ray_toward_box();
    logic [383:0] b;
    logic [31:0]  o, d, c, h;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      o = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      d = $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      c = o + ($signed(d) * $signed($urandom_range(0, 64)));
      h = $urandom_range(1, 32'h0004_0000);
      b[ax*32 +: 32] = c - h;
      b[(3+ax)*32 +: 32] = c + h;
      b[(6+ax)*32 +: 32] = o;
      b[(9+ax)*32 +: 32] = d;
    end
    return b;
  endfunction

  task automatic send_beat(logic [383:0] beat);
    int g;
    bit acc;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tdata <= beat;
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      acc = s_tready;
      @(posedge clk);
    end while (!acc);
  endtask

  always @(posedge clk) begin
    if (rx_stall_on && $urandom_range(0, 3) == 0) m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [383:0] beat;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: all-extreme fields, zero directions, swapped corners and a miss
    send_beat('0);
    send_beat({12{32'h8000_0000}});
    send_beat({12{32'h7fff_ffff}});
    send_beat({12{32'hffff_ffff}});
    send_beat({{3{32'h0}}, {3{32'h0}}, {3{32'h0001_0000}}, {3{32'hffff_0000}}});
    send_beat({{3{32'h0}}, {3{32'h0}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
    send_beat({{3{32'h0}}, {3{32'h0}}, {3{32'hffff_0000}}, {3{32'h0001_0000}}});
    send_beat({{3{32'h0001_0000}}, {3{32'h0}}, {3{32'h0003_0000}}, {3{32'h0002_0000}}});
    send_beat({{3{32'h0001_0000}}, {3{32'h0}}, {3{32'h0002_0000}}, {3{32'h0003_0000}}});
    send_beat({{3{32'hffff_0000}}, {3{32'h0}}, {3{32'hfffe_0000}}, {3{32'hfffd_0000}}});
    send_beat({32'h0001_0000, 32'h0, 32'h0, {3{32'h0}}, {3{32'h0002_0000}},
               {3{32'h0001_0000}}});
    send_beat({32'h1, 32'h1, 32'h7fff_ffff, {3{32'h0}}, {3{32'h8000_0000}},
               {3{32'h7fff_ffff}}});
    send_beat({32'h3, 32'hffff_fffd, 32'h7, {3{32'h0}}, {3{32'h0}}, {3{32'h0001_0000}}});
    s_tvalid <= 1'b0;
    // hold off until the pipe drains
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
    for (int i = 0; i < 500; i++) begin
      if (i == 250) rx_stall_on = 1'b0;
      if (i == 350) rx_stall_on = 1'b1;
      if ($urandom_range(0, 9) < 6) beat = ray_toward_box();
      else begin
        for (int f = 0; f < 9; f++) beat[f*32 +: 32] = coord_pick();
        for (int f = 9; f < 12; f++) beat[f*32 +: 32] = dir_pick();
      end
      send_beat(beat);
    end
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
